/* hw/rtl/sbb_pkg.sv */
// Shared types, constants and helper functions for the shape bounding box block.
// Used by the CORDIC cell, the extent unit and the top level; depends on nothing.
package sbb_pkg;

  // CORDIC datapath widths: x and y are Q1.30 with headroom, z is in 2^-32 turn.
  localparam int unsigned CordicW   = 34;
  localparam int unsigned AtanCount = 24;
  localparam int unsigned ExtW      = 33;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032875;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic signed [CordicW-1:0] AtanTurn [AtanCount] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
  } sbb_cordic_t;

  // Shape data that rides along the pipeline with each word.
  typedef struct packed {
    logic               is_box;
    logic               flip;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        radius;
    logic [30:0]        half_len_x;
    logic [30:0]        half_len_y;
  } sbb_side_t;

  // Round a Q1.30 value to Q1.15 with saturation.
  function automatic logic signed [15:0] sbb_to_q15(logic signed [CordicW-1:0] v);
    logic signed [CordicW:0]   biased;
    logic signed [CordicW-15:0] shifted;
    logic signed [15:0]        res;
    biased  = (CordicW+1)'(v) + (CordicW+1)'(16384);
    shifted = biased[CordicW:15];
    if (shifted > (CordicW-14)'(32767)) begin
      res = 16'sh7fff;
    end else if (shifted < -(CordicW-14)'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = shifted[15:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/sbb_cordic_cell.sv */
// One rotation-mode CORDIC cell of the shape bounding box pipeline.
// Depends on sbb_pkg for the datapath types and the arctangent table.
module sbb_cordic_cell import sbb_pkg::*; #(
  parameter int unsigned Stage = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  sbb_cordic_t state_i,
  input  sbb_side_t   side_i,
  output logic        valid_o,
  output sbb_cordic_t state_o,
  output sbb_side_t   side_o
);

  logic                      valid_q;
  sbb_cordic_t               state_d, state_q;
  sbb_side_t                 side_q;
  logic signed [CordicW-1:0] dx, dy;

  always_comb begin
    dx = state_i.y >>> Stage;
    dy = state_i.x >>> Stage;
    if (state_i.z >= 0) begin
      state_d.x = state_i.x - dx;
      state_d.y = state_i.y + dy;
      state_d.z = state_i.z - AtanTurn[Stage];
    end else begin
      state_d.x = state_i.x + dx;
      state_d.y = state_i.y - dy;
      state_d.z = state_i.z + AtanTurn[Stage];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign side_o  = side_q;

endmodule

/* hw/rtl/sbb_extent.sv */
// Extent unit: turns the CORDIC result into Q1.15 cos and sin and the x and y
// half extents of the shape over three register stages. Depends on sbb_pkg.
module sbb_extent import sbb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  sbb_cordic_t              state_i,
  input  sbb_side_t                side_i,
  output logic                     valid_o,
  output logic [ExtW-1:0]          ext_x_o,
  output logic [ExtW-1:0]          ext_y_o,
  output logic signed [15:0]       axis_cos_o,
  output logic signed [15:0]       axis_sin_o,
  output sbb_side_t                side_o
);

  // Stage A: undo the half-turn fold, round to Q1.15, take magnitudes.
  logic                      a_valid_q;
  sbb_side_t                 a_side_q;
  logic signed [15:0]        a_cos_d, a_sin_d, a_cos_q, a_sin_q;
  logic [15:0]               a_acos_q, a_asin_q;
  logic signed [CordicW-1:0] x_unf, y_unf;
  logic [16:0]               acos_w, asin_w;

  // Stage B: four products of magnitude by half size.
  logic                      b_valid_q;
  sbb_side_t                 b_side_q;
  logic signed [15:0]        b_cos_q, b_sin_q;
  logic [46:0]               b_cw_q, b_sh_q, b_sw_q, b_ch_q;

  // Stage C: round the sums to Q16.16.
  logic                      c_valid_q;
  sbb_side_t                 c_side_q;
  logic signed [15:0]        c_cos_q, c_sin_q;
  logic [ExtW-1:0]           c_ext_x_q, c_ext_y_q;
  logic [47:0]               sum_x, sum_y;

  always_comb begin
    x_unf   = side_i.flip ? -state_i.x : state_i.x;
    y_unf   = side_i.flip ? -state_i.y : state_i.y;
    a_cos_d = sbb_to_q15(x_unf);
    a_sin_d = sbb_to_q15(y_unf);
    acos_w  = a_cos_d[15] ? -{a_cos_d[15], a_cos_d} : {a_cos_d[15], a_cos_d};
    asin_w  = a_sin_d[15] ? -{a_sin_d[15], a_sin_d} : {a_sin_d[15], a_sin_d};
    sum_x   = 48'(b_cw_q) + 48'(b_sh_q) + 48'd16384;
    sum_y   = 48'(b_sw_q) + 48'(b_ch_q) + 48'd16384;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q <= side_i;
      a_cos_q  <= a_cos_d;
      a_sin_q  <= a_sin_d;
      a_acos_q <= acos_w[15:0];
      a_asin_q <= asin_w[15:0];

      b_side_q <= a_side_q;
      b_cos_q  <= a_cos_q;
      b_sin_q  <= a_sin_q;
      b_cw_q   <= 47'(a_acos_q) * 47'(a_side_q.half_len_x);
      b_sh_q   <= 47'(a_asin_q) * 47'(a_side_q.half_len_y);
      b_sw_q   <= 47'(a_asin_q) * 47'(a_side_q.half_len_x);
      b_ch_q   <= 47'(a_acos_q) * 47'(a_side_q.half_len_y);

      c_side_q <= b_side_q;
      if (b_side_q.is_box) begin
        c_cos_q   <= b_cos_q;
        c_sin_q   <= b_sin_q;
        c_ext_x_q <= sum_x[47:15];
        c_ext_y_q <= sum_y[47:15];
      end else begin
        c_cos_q   <= 16'sh7fff;
        c_sin_q   <= 16'sh0000;
        c_ext_x_q <= ExtW'(b_side_q.radius);
        c_ext_y_q <= ExtW'(b_side_q.radius);
      end
    end
  end

  assign valid_o    = c_valid_q;
  assign ext_x_o    = c_ext_x_q;
  assign ext_y_o    = c_ext_y_q;
  assign axis_cos_o = c_cos_q;
  assign axis_sin_o = c_sin_q;
  assign side_o     = c_side_q;

endmodule

/* hw/rtl/shape_bounding_box_top.sv */
// Top level of the shape bounding box block: angle folding, the CORDIC cell
// chain, the extent unit and the saturating bound stage. Depends on sbb_pkg.

// The block takes one shape word per clock while in_stall_o is low and returns
// one bounding box word per shape, in order. Each shape passes through the
// chain of CORDIC cells (one cell per stage), then three extent stages (Q1.15
// rounding, the multipliers, the rounded sums) and the output register that
// holds the saturated bounds, where the box word waits until it is taken with
// out_stall_i low. Circles pass through the same pipeline and keep their place
// in the stream. The whole pipeline advances together: it moves whenever the
// output register is empty or being taken, so in_stall_o rises only while a
// finished word waits under out_stall_i, and a new shape enters in the same
// cycle as the waiting word leaves. Bounds saturate to the signed
// COORD_WIDTH-bit range and the ports carry the low 32 bits of that value.
module shape_bounding_box_top import sbb_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned COORD_WIDTH   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               shape_is_box_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [30:0]        radius_i,
  input  logic [30:0]        half_len_x_i,
  input  logic [30:0]        half_len_y_i,
  input  logic [15:0]        angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] min_x_o,
  output logic signed [31:0] max_x_o,
  output logic signed [31:0] min_y_o,
  output logic signed [31:0] max_y_o,
  output logic signed [15:0] axis_cos_o,
  output logic signed [15:0] axis_sin_o
);

  // Width of centre plus or minus an extent, and of the saturation compare.
  localparam int unsigned SumW = 35;
  localparam int unsigned CmpW = (COORD_WIDTH > SumW) ? COORD_WIDTH : SumW;
  localparam logic signed [CmpW-1:0] CoordHi =
    signed'({{(CmpW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [CmpW-1:0] CoordLo = ~CoordHi;

  function automatic logic [31:0] sat_bound(logic signed [SumW-1:0] v);
    logic signed [CmpW-1:0] w;
    logic signed [CmpW-1:0] r;
    w = CmpW'(v);
    if (w > CoordHi) begin
      r = CoordHi;
    end else if (w < CoordLo) begin
      r = CoordLo;
    end else begin
      r = w;
    end
    return r[31:0];
  endfunction

  // The pipeline advances when the output register is free or being taken.
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Fold the angle into a quarter turn either side of zero. Angles in the
  // left half plane lose half a turn, and the CORDIC result is negated later.
  logic               fold_flip;
  logic signed [15:0] fold_angle;

  assign fold_flip  = angle_i[15] ^ angle_i[14];
  assign fold_angle = signed'(fold_flip ? (angle_i ^ 16'h8000) : angle_i);

  logic        cell_valid [CORDIC_STAGES+1];
  sbb_cordic_t cell_state [CORDIC_STAGES+1];
  sbb_side_t   cell_side  [CORDIC_STAGES+1];

  assign cell_valid[0]   = in_valid_i;
  assign cell_state[0].x = CordicGain;
  assign cell_state[0].y = '0;
  assign cell_state[0].z = {{(CordicW-32){fold_angle[15]}}, fold_angle, 16'h0000};

  assign cell_side[0].is_box     = shape_is_box_i;
  assign cell_side[0].flip       = fold_flip;
  assign cell_side[0].pos_x      = pos_x_i;
  assign cell_side[0].pos_y      = pos_y_i;
  assign cell_side[0].radius     = radius_i;
  assign cell_side[0].half_len_x = half_len_x_i;
  assign cell_side[0].half_len_y = half_len_y_i;

  // Each cell performs one micro-rotation and hands its word to the next.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    sbb_cordic_cell #(
      .Stage (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[g]),
      .state_i (cell_state[g]),
      .side_i  (cell_side[g]),
      .valid_o (cell_valid[g+1]),
      .state_o (cell_state[g+1]),
      .side_o  (cell_side[g+1])
    );
  end

  logic               ext_valid;
  logic [ExtW-1:0]    ext_x, ext_y;
  logic signed [15:0] ext_cos, ext_sin;
  sbb_side_t          ext_side;

  sbb_extent u_extent (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (cell_valid[CORDIC_STAGES]),
    .state_i    (cell_state[CORDIC_STAGES]),
    .side_i     (cell_side[CORDIC_STAGES]),
    .valid_o    (ext_valid),
    .ext_x_o    (ext_x),
    .ext_y_o    (ext_y),
    .axis_cos_o (ext_cos),
    .axis_sin_o (ext_sin),
    .side_o     (ext_side)
  );

  // Centre plus or minus the extent, with room for the carry either way.
  logic signed [SumW-1:0] px_w, py_w, ex_w, ey_w;
  logic [31:0]            min_x_d, max_x_d, min_y_d, max_y_d;
  logic [31:0]            min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [15:0]     cos_q, sin_q;

  always_comb begin
    px_w    = SumW'(ext_side.pos_x);
    py_w    = SumW'(ext_side.pos_y);
    ex_w    = signed'({{(SumW-ExtW){1'b0}}, ext_x});
    ey_w    = signed'({{(SumW-ExtW){1'b0}}, ext_y});
    min_x_d = sat_bound(px_w - ex_w);
    max_x_d = sat_bound(px_w + ex_w);
    min_y_d = sat_bound(py_w - ey_w);
    max_y_d = sat_bound(py_w + ey_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ext_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
      cos_q   <= ext_cos;
      sin_q   <= ext_sin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_x_o     = signed'(min_x_q);
  assign max_x_o     = signed'(max_x_q);
  assign min_y_o     = signed'(min_y_q);
  assign max_y_o     = signed'(max_y_q);
  assign axis_cos_o  = cos_q;
  assign axis_sin_o  = sin_q;

  // The input side is held back only by a finished word that waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting output word");

  // While the pipeline is held, the valid flags at the end of the CORDIC chain and of the extent unit stay unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(cell_valid[CORDIC_STAGES]) && $stable(ext_valid)))
    else $error("pipeline occupancy changed while stalled");

  // Extents are never negative, so bounds stay ordered when no wrap occurs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((COORD_WIDTH > 32) ||
                     ((min_x_o <= max_x_o) && (min_y_o <= max_y_o))))
    else $error("bounding box lower bound exceeds upper bound");

  // A circle word carries the fixed axis of an unrotated shape.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ext_valid && en && !ext_side.is_box) |=>
      ((axis_cos_o == 16'sh7fff) && (axis_sin_o == 16'sh0000)))
    else $error("circle word left the pipeline with a rotated axis");

endmodule
